/* rtl/census_sad_window_cost_core_defines.svh */
// assertion macros for the census / sad cost core checker
`ifndef CENSUS_SAD_WINDOW_COST_CORE_DEFINES_SVH
`define CENSUS_SAD_WINDOW_COST_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CSW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/csw_pkg.sv */
package csw_pkg;

	localparam int FIELD_LANES = 4;
	localparam int LANES       = 4;
	localparam int ACT_LANES   = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;

	localparam int PIX_W      = 8;
	localparam int DIFF_SUM_W = PIX_W + ((ACT_LANES > 1) ? $clog2(ACT_LANES) : 0);
	localparam int CNT_W      = $clog2(ACT_LANES + 1);

	localparam int SAD_ACC_W = 17;
	localparam int CEN_ACC_W = 9;
	localparam int SAD_FRAC  = 8;
	localparam int CEN_FRAC  = 16;

	localparam int NORM_SIDE = 21;
	localparam int NORM_DIV  = NORM_SIDE * NORM_SIDE;
	localparam int HALF_DIV  = NORM_DIV / 2;
	localparam int DIV_W     = $clog2(NORM_DIV + 1);

	localparam int NUM_W       = SAD_ACC_W + SAD_FRAC;
	localparam int RECIP_SHIFT = NUM_W + 1;
	localparam int RECIP_W     = 18;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / NORM_DIV);
	localparam int PROD_W = NUM_W + RECIP_W;
	localparam int Q_W    = PROD_W - RECIP_SHIFT;
	localparam int QM_W   = Q_W + DIV_W;
	localparam int REM_W  = DIV_W + 1;

	localparam int COST_W = 16;
	localparam logic [COST_W-1:0] COST_MAX = '1;

	typedef struct packed {
		logic load_s1;
		logic take_s1;
		logic load_s2;
		logic load_s3;
		logic load_s4;
	} pipe_en_t;

endpackage

/* rtl/csw_lane.sv */
module csw_lane
	import csw_pkg::*;
(
	input  logic             clk,
	input  pipe_en_t         en,
	input  logic [PIX_W-1:0] left_pix,
	input  logic [PIX_W-1:0] right_pix,
	input  logic [PIX_W-1:0] left_center,
	input  logic [PIX_W-1:0] right_center,
	output logic [PIX_W-1:0] diff_s1,
	output logic             miss_s1
);

	logic [PIX_W-1:0] diff;
	logic             lbit;
	logic             rbit;

	assign diff = (left_pix >= right_pix) ? (left_pix - right_pix) : (right_pix - left_pix);
	// census bit: pixel not below its center
	assign lbit = (left_pix >= left_center);
	assign rbit = (right_pix >= right_center);

	always_ff @(posedge clk) begin
		if (en.load_s1) begin
			diff_s1 <= diff;
			miss_s1 <= lbit ^ rbit;
		end
	end

endmodule

/* rtl/csw_merge.sv */
module csw_merge
	import csw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  pipe_en_t             en,
	input  logic                 end_s1,
	input  logic [PIX_W-1:0]     diff_s1 [ACT_LANES],
	input  logic                 miss_s1 [ACT_LANES],
	output logic [SAD_ACC_W-1:0] sad_sum_s2,
	output logic [CEN_ACC_W-1:0] cen_sum_s2
);

	logic [SAD_ACC_W-1:0]  sad_acc_q;
	logic [CEN_ACC_W-1:0]  cen_acc_q;
	logic [DIFF_SUM_W-1:0] diff_sum;
	logic [CNT_W-1:0]      miss_cnt;
	logic [SAD_ACC_W:0]    sad_tot;
	logic [CEN_ACC_W:0]    cen_tot;
	logic [SAD_ACC_W-1:0]  sad_sat;
	logic [CEN_ACC_W-1:0]  cen_sat;

	always_comb begin
		diff_sum = '0;
		miss_cnt = '0;
		for (int i = 0; i < ACT_LANES; i++) begin
			diff_sum = diff_sum + DIFF_SUM_W'(diff_s1[i]);
			miss_cnt = miss_cnt + CNT_W'(miss_s1[i]);
		end
		sad_tot = {1'b0, sad_acc_q} + (SAD_ACC_W + 1)'(diff_sum);
		cen_tot = {1'b0, cen_acc_q} + (CEN_ACC_W + 1)'(miss_cnt);
		// all terms are non-negative, so clamping the total matches per-lane clamping
		sad_sat = sad_tot[SAD_ACC_W] ? '1 : sad_tot[SAD_ACC_W-1:0];
		cen_sat = cen_tot[CEN_ACC_W] ? '1 : cen_tot[CEN_ACC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sad_acc_q <= '0;
			cen_acc_q <= '0;
		end else if (en.take_s1) begin
			sad_acc_q <= end_s1 ? '0 : sad_sat;
			cen_acc_q <= end_s1 ? '0 : cen_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en.load_s2) begin
			sad_sum_s2 <= sad_sat;
			cen_sum_s2 <= cen_sat;
		end
	end

endmodule

/* rtl/csw_div441.sv */
module csw_div441
	import csw_pkg::*;
(
	input  logic              clk,
	input  pipe_en_t          en,
	input  logic [NUM_W-1:0]  num_s2,
	output logic [COST_W-1:0] cost_s4
);

	logic [NUM_W-1:0]  num_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [Q_W-1:0]    q_est;
	logic [QM_W-1:0]   qm;
	logic [REM_W-1:0]  rem;
	logic [Q_W-1:0]    q;

	always_ff @(posedge clk) begin
		if (en.load_s3) begin
			num_s3  <= num_s2;
			prod_s3 <= PROD_W'(num_s2) * PROD_W'(RECIP);
		end
	end

	// reciprocal estimate is exact or one low
	always_comb begin
		q_est = prod_s3[PROD_W-1:RECIP_SHIFT];
		qm    = QM_W'(q_est) * QM_W'(NORM_DIV);
		rem   = REM_W'(QM_W'(num_s3) - qm);
		q     = q_est + Q_W'(rem >= REM_W'(NORM_DIV));
	end

	always_ff @(posedge clk) begin
		if (en.load_s4) begin
			cost_s4 <= (q > Q_W'(COST_MAX)) ? COST_MAX : q[COST_W-1:0];
		end
	end

endmodule

/* rtl/census_sad_window_cost_core.sv */
// channel  handshake               payload
// pix      pix_valid / pix_ready   left_pix0..3, right_pix0..3, left_center,
//                                  right_center, window_end
// cost     cost_valid / cost_ready sad_cost, census_cost
//
// one pixel beat per clock while pix_ready is high; lanes work in parallel and the merge accumulates per beat
// a window_end beat passes the register stages (lanes, merge, reciprocal multiply,
// correction) in that order before it can be taken as a cost beat
// arst_n clears the stage valids and both accumulators
// an end beat waits in the first stage only while all cost stages downstream are
// full and cost_ready is low; any beat behind it waits at the input meanwhile
module census_sad_window_cost_core
	import csw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  logic [PIX_W-1:0]  left_pix0,
	input  logic [PIX_W-1:0]  left_pix1,
	input  logic [PIX_W-1:0]  left_pix2,
	input  logic [PIX_W-1:0]  left_pix3,
	input  logic [PIX_W-1:0]  right_pix0,
	input  logic [PIX_W-1:0]  right_pix1,
	input  logic [PIX_W-1:0]  right_pix2,
	input  logic [PIX_W-1:0]  right_pix3,
	input  logic [PIX_W-1:0]  left_center,
	input  logic [PIX_W-1:0]  right_center,
	input  logic              window_end,
	output logic              cost_valid,
	input  logic              cost_ready,
	output logic [COST_W-1:0] sad_cost,
	output logic [COST_W-1:0] census_cost
);

	logic [PIX_W-1:0]     left_arr  [FIELD_LANES];
	logic [PIX_W-1:0]     right_arr [FIELD_LANES];
	logic [PIX_W-1:0]     diff_s1   [ACT_LANES];
	logic                 miss_s1   [ACT_LANES];
	logic                 end_s1;
	logic                 v_s1;
	logic                 v_s2;
	logic                 v_s3;
	logic                 v_s4;
	logic                 free2;
	logic                 free3;
	logic                 free4;
	logic [SAD_ACC_W-1:0] sad_sum_s2;
	logic [CEN_ACC_W-1:0] cen_sum_s2;
	logic [NUM_W-1:0]     sad_num_s2;
	logic [NUM_W-1:0]     cen_num_s2;
	pipe_en_t             en;

	assign left_arr[0]  = left_pix0;
	assign left_arr[1]  = left_pix1;
	assign left_arr[2]  = left_pix2;
	assign left_arr[3]  = left_pix3;
	assign right_arr[0] = right_pix0;
	assign right_arr[1] = right_pix1;
	assign right_arr[2] = right_pix2;
	assign right_arr[3] = right_pix3;

	always_comb begin
		free4      = !v_s4 || cost_ready;
		free3      = !v_s3 || free4;
		free2      = !v_s2 || free3;
		en.load_s4 = v_s3 && free4;
		en.load_s3 = v_s2 && free3;
		en.take_s1 = v_s1 && (!end_s1 || free2);
		en.load_s2 = v_s1 && end_s1 && free2;
		pix_ready  = !v_s1 || en.take_s1;
		en.load_s1 = pix_valid && pix_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= en.load_s1 || (v_s1 && !en.take_s1);
			v_s2 <= en.load_s2 || (v_s2 && !en.load_s3);
			v_s3 <= en.load_s3 || (v_s3 && !en.load_s4);
			v_s4 <= en.load_s4 || (v_s4 && !cost_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (en.load_s1) begin
			end_s1 <= window_end;
		end
	end

	for (genvar g = 0; g < ACT_LANES; g++) begin : g_lane
		csw_lane u_lane (
			.clk          (clk),
			.en           (en),
			.left_pix     (left_arr[g]),
			.right_pix    (right_arr[g]),
			.left_center  (left_center),
			.right_center (right_center),
			.diff_s1      (diff_s1[g]),
			.miss_s1      (miss_s1[g])
		);
	end

	csw_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.end_s1     (end_s1),
		.diff_s1    (diff_s1),
		.miss_s1    (miss_s1),
		.sad_sum_s2 (sad_sum_s2),
		.cen_sum_s2 (cen_sum_s2)
	);

	// scale to fixed point and add half the divisor for rounding
	assign sad_num_s2 = {sad_sum_s2, SAD_FRAC'(HALF_DIV)};
	assign cen_num_s2 = {cen_sum_s2, CEN_FRAC'(HALF_DIV)};

	csw_div441 u_div_sad (
		.clk     (clk),
		.en      (en),
		.num_s2  (sad_num_s2),
		.cost_s4 (sad_cost)
	);

	csw_div441 u_div_cen (
		.clk     (clk),
		.en      (en),
		.num_s2  (cen_num_s2),
		.cost_s4 (census_cost)
	);

	assign cost_valid = v_s4;

endmodule

/* rtl/csw_checker.sv */
`include "census_sad_window_cost_core_defines.svh"

module csw_checker
	import csw_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              pix_valid,
	input logic              pix_ready,
	input logic [PIX_W-1:0]  left_pix0,
	input logic [PIX_W-1:0]  left_pix1,
	input logic [PIX_W-1:0]  left_pix2,
	input logic [PIX_W-1:0]  left_pix3,
	input logic [PIX_W-1:0]  right_pix0,
	input logic [PIX_W-1:0]  right_pix1,
	input logic [PIX_W-1:0]  right_pix2,
	input logic [PIX_W-1:0]  right_pix3,
	input logic [PIX_W-1:0]  left_center,
	input logic [PIX_W-1:0]  right_center,
	input logic              window_end,
	input logic              cost_valid,
	input logic              cost_ready,
	input logic [COST_W-1:0] sad_cost,
	input logic [COST_W-1:0] census_cost
);

	// a stalled cost beat holds
	`CSW_ASSERT_NEXT(a_cost_hold, cost_valid && !cost_ready, cost_valid && $stable(sad_cost) && $stable(census_cost), "cost beat changed while stalled")

	// a cost beat leaves only when taken
	`CSW_ASSERT_NOW(a_cost_drop, $fell(cost_valid), $past(cost_ready), "cost beat dropped without handshake")

	// pixel side stalls only behind a full, stalled cost stage
	`CSW_ASSERT_NOW(a_backpressure, !pix_ready, cost_valid && !cost_ready, "pixel stall with room downstream")

	// an end beat into an empty output shows up after the lane, merge, multiply and correction registers
	`CSW_ASSERT_NEXT(a_latency, (pix_valid && pix_ready && window_end && !cost_valid) ##1 !cost_valid ##1 !cost_valid ##1 !cost_valid, cost_valid, "end beat result missing")

endmodule

bind census_sad_window_cost_core csw_checker u_chk (.*);
